/* design/dcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants for the day count to date converter
// Field widths, calendar constants, the month length table and the status
// structs that pass between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int unsigned COUNT_W = 22;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned WDAY_W  = 3;

    // Day counts
    localparam logic [COUNT_W-1:0] LAST_COUNT     = 22'd2921939;
    localparam logic [COUNT_W-1:0] DAYS_400       = 22'd146097;
    localparam logic [COUNT_W-1:0] DAYS_CENT_LEAP = 22'd36525;
    localparam logic [COUNT_W-1:0] DAYS_CENT      = 22'd36524;
    localparam logic [COUNT_W-1:0] DAYS_4Y        = 22'd1461;
    localparam logic [COUNT_W-1:0] DAYS_LEAP_YEAR = 22'd366;
    localparam logic [COUNT_W-1:0] DAYS_YEAR      = 22'd365;

    // Year counts
    localparam logic [YEAR_W-1:0] YEAR_BASE  = 14'd2000;
    localparam logic [YEAR_W-1:0] YEARS_400  = 14'd400;
    localparam logic [YEAR_W-1:0] YEARS_CENT = 14'd100;
    localparam logic [YEAR_W-1:0] YEARS_4    = 14'd4;

    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd10;

    typedef struct packed {
        logic               ge;
        logic [COUNT_W-1:0] diff;
    } sub_res_t;

    typedef struct packed {
        logic              ready;
        logic [WDAY_W-1:0] rem;
    } mod7_stat_t;

    // Days in month, month numbered from zero
    function automatic logic [DAY_W-1:0] month_len(logic leap, logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* design/dcc_sub_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_sub_unit: shared compare and subtract unit
// Computes a - b and whether a >= b from one subtractor with borrow.
// ----------------------------------------------------------------------------
module dcc_sub_unit (
    input  logic [dcc_pkg::COUNT_W-1:0] a,
    input  logic [dcc_pkg::COUNT_W-1:0] b,
    output dcc_pkg::sub_res_t           res
);
    import dcc_pkg::*;

    logic               borrow;
    logic [COUNT_W-1:0] diff;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign res.ge   = ~borrow;
    assign res.diff = diff;

endmodule

/* design/dcc_mod7.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_mod7: remainder by seven
// Since 8 is 1 modulo 7, folds the count in 3-bit groups: the loaded count
// is registered, then its group sum, which is folded twice more to the
// registered remainder.
// ----------------------------------------------------------------------------
module dcc_mod7 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [dcc_pkg::COUNT_W-1:0] value,
    output dcc_pkg::mod7_stat_t         stat
);
    import dcc_pkg::*;

    localparam int unsigned CHUNKS = (COUNT_W + 2) / 3;
    localparam int unsigned PAD_W  = 3 * CHUNKS;
    localparam int unsigned SUM_W  = 6;
    localparam logic [1:0]  STAGES = 2'd2;

    logic [COUNT_W-1:0] value_reg, value_next;
    logic [SUM_W-1:0]   fold_reg, fold_next;
    logic [WDAY_W-1:0]  rem_reg, rem_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [PAD_W-1:0]   padded;
    logic [3:0]         fold2;
    logic [3:0]         fold3;

    assign padded = {{(PAD_W - COUNT_W){1'b0}}, value_reg};

    // Sum the 3-bit groups of the held count
    always_comb
    begin
        fold_next = '0;
        for (int i = 0; i < int'(CHUNKS); i++)
            fold_next = fold_next + SUM_W'(padded[3*i +: 3]);
    end

    assign fold2 = {1'b0, fold_reg[5:3]} + {1'b0, fold_reg[2:0]};
    assign fold3 = {1'b0, fold2[2:0]} + {3'b000, fold2[3]};

    always_comb
    begin
        value_next = value_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            value_next = value;
            cnt_next   = STAGES;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            // last fold: seven wraps to zero
            if (cnt_reg == 2'd1)
                rem_next = (fold3 == 4'd7) ? '0 : fold3[WDAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        fold_reg  <= fold_next;
    end

    assign stat.ready = (cnt_reg == '0);
    assign stat.rem   = rem_reg;

    a_rem_below_seven: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd6)
        else $error("mod7 remainder out of range");

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> !stat.ready)
        else $error("mod7 ready right after load");

    a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.ready && !load) |=> (stat.ready && $stable(rem_reg)))
        else $error("mod7 result changed without a load");

endmodule

/* design/day_count_to_calendar_date_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_core: day count to Gregorian date converter
// Turns a count of days since 2000-01-01 into year, month, day and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   Drive day_count and raise start while busy is low; that edge takes the
//   transaction and busy goes high until the result is out.
//   The result appears on year, month, day_of_month, weekday and
//   out_of_range, marked by done, high for exactly one cycle. There is no
//   backpressure: the receiver must capture it on that cycle.
//   The steps run on the one shared subtractor: range check, 5 steps of
//   400-year division, 1 to 4 century steps, one shift step, 5 steps of
//   4-year division, one unshift step, 1 to 4 year steps, 1 to 12 month
//   steps and one step to register the result and raise done. The weekday
//   remainder runs alongside and is ready before that last step, so it
//   never adds latency. A count past 9999-12-31 stops after the range check
//   and raises done with out_of_range set and the other fields zero. busy
//   drops on the cycle done is high, so the next start may be taken at the
//   edge ending that cycle, and not before the last result is out.
//   Reset (rst_n low) returns the sequencer to idle and clears done; no
//   conversion in flight survives it.
// ----------------------------------------------------------------------------
module day_count_to_calendar_date_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dcc_pkg::COUNT_W-1:0] day_count,
    output logic                        done,
    output logic [dcc_pkg::YEAR_W-1:0]  year,
    output logic [dcc_pkg::MONTH_W-1:0] month,
    output logic [dcc_pkg::DAY_W-1:0]   day_of_month,
    output logic [dcc_pkg::WDAY_W-1:0]  weekday,
    output logic                        out_of_range
);
    import dcc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_RANGE  = 10'b00_0000_0010,
        S_DIV400 = 10'b00_0000_0100,
        S_CENT   = 10'b00_0000_1000,
        S_FIX1   = 10'b00_0001_0000,
        S_DIV4   = 10'b00_0010_0000,
        S_FIX2   = 10'b00_0100_0000,
        S_YEARS  = 10'b00_1000_0000,
        S_MONTHS = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    localparam logic [2:0] DIV_TOP = 3'd4;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] d_reg, d_next;
    logic [YEAR_W-1:0]  yr_acc_reg, yr_acc_next;
    logic [1:0]         c_reg, c_next;
    logic [1:0]         y_reg, y_next;
    logic [MONTH_W-1:0] m_reg, m_next;
    logic [2:0]         k_reg, k_next;
    logic               q4nz_reg, q4nz_next;
    logic               noleap_reg, noleap_next;

    logic               done_reg, done_next;
    logic [YEAR_W-1:0]  res_year_reg, res_year_next;
    logic [MONTH_W-1:0] res_month_reg, res_month_next;
    logic [DAY_W-1:0]   res_day_reg, res_day_next;
    logic [WDAY_W-1:0]  res_wday_reg, res_wday_next;
    logic               res_oor_reg, res_oor_next;

    logic [COUNT_W-1:0] sub_b;
    sub_res_t           sub;
    mod7_stat_t         m7;
    logic               m7_load;
    logic [YEAR_W-1:0]  yr_inc;
    logic               leap;

    dcc_sub_unit u_sub (
        .a   (d_reg),
        .b   (sub_b),
        .res (sub)
    );

    assign m7_load = (state_reg == S_IDLE) && start;

    dcc_mod7 u_mod7 (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (m7_load),
        .value (day_count),
        .stat  (m7)
    );

    assign leap = (y_reg == 2'd0) && !noleap_reg;

    // Operand for the shared subtractor
    always_comb
    begin
        unique case (state_reg)
            S_RANGE:  sub_b = LAST_COUNT + 1'b1;
            S_DIV400: sub_b = DAYS_400 << k_reg;
            S_CENT:   sub_b = (c_reg == 2'd0) ? DAYS_CENT_LEAP : DAYS_CENT;
            // subtracting all ones adds one: later centuries skip the leap
            // day of their first year, so shift them onto the 1461 grid
            S_FIX1:   sub_b = (c_reg != 2'd0) ? '1 : '0;
            S_DIV4:   sub_b = DAYS_4Y << k_reg;
            // undo the shift when still in the first four years of the century
            S_FIX2:   sub_b = (c_reg != 2'd0 && !q4nz_reg) ? COUNT_W'(1) : '0;
            S_YEARS:  sub_b = (y_reg == 2'd0 && !noleap_reg) ? DAYS_LEAP_YEAR : DAYS_YEAR;
            S_MONTHS: sub_b = COUNT_W'(month_len(leap, m_reg));
            default:  sub_b = '0;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_DIV400: yr_inc = YEARS_400 << k_reg;
            S_CENT:   yr_inc = YEARS_CENT;
            S_DIV4:   yr_inc = YEARS_4 << k_reg;
            S_YEARS:  yr_inc = YEAR_W'(1);
            default:  yr_inc = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        d_next         = d_reg;
        yr_acc_next    = yr_acc_reg;
        c_next         = c_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        q4nz_next      = q4nz_reg;
        noleap_next    = noleap_reg;
        done_next      = 1'b0;
        res_year_next  = res_year_reg;
        res_month_next = res_month_reg;
        res_day_next   = res_day_reg;
        res_wday_next  = res_wday_reg;
        res_oor_next   = res_oor_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    d_next      = day_count;
                    yr_acc_next = YEAR_BASE;
                    c_next      = '0;
                    y_next      = '0;
                    m_next      = '0;
                    k_next      = DIV_TOP;
                    q4nz_next   = 1'b0;
                    state_next  = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (sub.ge)
                begin
                    done_next      = 1'b1;
                    res_year_next  = '0;
                    res_month_next = '0;
                    res_day_next   = '0;
                    res_wday_next  = '0;
                    res_oor_next   = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_DIV400;
                end
            end
            S_DIV400:
            begin
                if (sub.ge)
                begin
                    d_next      = sub.diff;
                    yr_acc_next = yr_acc_reg + yr_inc;
                end
                if (k_reg == '0)
                    state_next = S_CENT;
                else
                    k_next = k_reg - 1'b1;
            end
            S_CENT:
            begin
                if (sub.ge && c_reg != 2'd3)
                begin
                    d_next      = sub.diff;
                    yr_acc_next = yr_acc_reg + yr_inc;
                    c_next      = c_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FIX1;
                end
            end
            S_FIX1:
            begin
                d_next     = sub.diff;
                k_next     = DIV_TOP;
                state_next = S_DIV4;
            end
            S_DIV4:
            begin
                if (sub.ge)
                begin
                    d_next      = sub.diff;
                    yr_acc_next = yr_acc_reg + yr_inc;
                    q4nz_next   = 1'b1;
                end
                if (k_reg == '0)
                    state_next = S_FIX2;
                else
                    k_next = k_reg - 1'b1;
            end
            S_FIX2:
            begin
                d_next      = sub.diff;
                noleap_next = (c_reg != 2'd0) && !q4nz_reg;
                state_next  = S_YEARS;
            end
            S_YEARS:
            begin
                if (sub.ge && y_reg != 2'd3)
                begin
                    d_next      = sub.diff;
                    yr_acc_next = yr_acc_reg + yr_inc;
                    y_next      = y_reg + 1'b1;
                end
                else
                begin
                    state_next = S_MONTHS;
                end
            end
            S_MONTHS:
            begin
                if (sub.ge && m_reg != MONTH_DEC)
                begin
                    d_next = sub.diff;
                    m_next = m_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the weekday remainder has finished
                if (m7.ready)
                begin
                    done_next      = 1'b1;
                    res_year_next  = yr_acc_reg;
                    res_month_next = m_reg + 1'b1;
                    res_day_next   = d_reg[DAY_W-1:0] + 1'b1;
                    res_wday_next  = m7.rem;
                    res_oor_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg         <= d_next;
        yr_acc_reg    <= yr_acc_next;
        c_reg         <= c_next;
        y_reg         <= y_next;
        m_reg         <= m_next;
        k_reg         <= k_next;
        q4nz_reg      <= q4nz_next;
        noleap_reg    <= noleap_next;
        res_year_reg  <= res_year_next;
        res_month_reg <= res_month_next;
        res_day_reg   <= res_day_next;
        res_wday_reg  <= res_wday_next;
        res_oor_reg   <= res_oor_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign year         = res_year_reg;
    assign month        = res_month_reg;
    assign day_of_month = res_day_reg;
    assign weekday      = res_wday_reg;
    assign out_of_range = res_oor_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |->
            (year == '0 && month == '0 && day_of_month == '0 && weekday == '0))
        else $error("out of range result carries nonzero fields");

    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !out_of_range) |->
            (year >= YEAR_BASE && year <= 14'd9999 && month >= 4'd1 &&
             month <= 4'd12 && day_of_month >= 5'd1 && weekday <= 3'd6))
        else $error("converted date out of legal range");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: day count to calendar date converter
// Starts conversions with random gaps and compares every result against a
// date predictor. Directed counts cover leap days, century and 400-year
// boundaries and the last valid date. Random counts are then drawn over the
// full range, near year boundaries and past the last date.
// ----------------------------------------------------------------------------
module testbench;

    import dcc_pkg::*;

    localparam int unsigned CLK_HALF       = 6;
    localparam int unsigned RESET_CYCLES   = 6;
    localparam int unsigned RANDOM_ITEMS   = 1750;
    localparam int unsigned DRAIN_EVERY    = 400;
    localparam int unsigned BURST_LEN      = 100;
    localparam int unsigned MAX_GAP        = 11;
    localparam int unsigned TAIL_CYCLES    = 40;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    localparam int unsigned FIRST_YEAR     = 2000;
    localparam int unsigned DAYS_IN_400Y   = 146097;
    localparam int unsigned DAYS_IN_CENT   = 36524;
    localparam int unsigned DAYS_IN_4Y     = 1461;
    localparam int unsigned FINAL_DAY      = 2921939;
    localparam int unsigned MAX_COUNT      = 4194303;
    localparam int unsigned FEB_INDEX      = 1;
    localparam int unsigned DEC_INDEX      = 11;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [WDAY_W-1:0]  weekday;
        logic               out_of_range;
    } cal_date_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        cal_date_t          date;
    } pending_date_t;

    class date_scoreboard;
        pending_date_t expected_dates[$];
        int unsigned   mismatches;
        int unsigned   conversions;
        int unsigned   past_last_date;

        function bit gregorian_leap(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        function cal_date_t predict_date(logic [COUNT_W-1:0] count);
            cal_date_t   r;
            int unsigned d;
            int unsigned yr;
            int unsigned m;
            int unsigned len;
            bit          leap;
            r = '0;
            d = count;
            if (d > FINAL_DAY)
            begin
                r.out_of_range = 1'b1;
                return r;
            end
            r.weekday = WDAY_W'(d % 7);
            yr = FIRST_YEAR + 400 * (d / DAYS_IN_400Y);
            d = d % DAYS_IN_400Y;
            len = gregorian_leap(yr) ? 366 : 365;
            while (d >= len)
            begin
                d -= len;
                yr++;
                len = gregorian_leap(yr) ? 366 : 365;
            end
            leap = gregorian_leap(yr);
            m = 0;
            len = MONTH_DAYS[0];
            while (m < DEC_INDEX && d >= len)
            begin
                d -= len;
                m++;
                len = MONTH_DAYS[m] + ((leap && m == FEB_INDEX) ? 1 : 0);
            end
            r.year         = YEAR_W'(yr);
            r.month        = MONTH_W'(m + 1);
            r.day_of_month = DAY_W'(d + 1);
            return r;
        endfunction

        function void note_count(logic [COUNT_W-1:0] count);
            pending_date_t p;
            p.count = count;
            p.date  = predict_date(count);
            expected_dates.push_back(p);
        endfunction

        function void check_date(cal_date_t got);
            pending_date_t p;
            if (expected_dates.size() == 0)
            begin
                $display("%0t: result with no transaction pending, got %h", $time, got);
                mismatches++;
                return;
            end
            p = expected_dates.pop_front();
            conversions++;
            if (p.date.out_of_range)
                past_last_date++;
            if (got.year !== p.date.year)
                $display("%0t: count %0d year expected %0d, actual %0d",
                         $time, p.count, p.date.year, got.year);
            if (got.month !== p.date.month)
                $display("%0t: count %0d month expected %0d, actual %0d",
                         $time, p.count, p.date.month, got.month);
            if (got.day_of_month !== p.date.day_of_month)
                $display("%0t: count %0d day_of_month expected %0d, actual %0d",
                         $time, p.count, p.date.day_of_month, got.day_of_month);
            if (got.weekday !== p.date.weekday)
                $display("%0t: count %0d weekday expected %0d, actual %0d",
                         $time, p.count, p.date.weekday, got.weekday);
            if (got.out_of_range !== p.date.out_of_range)
                $display("%0t: count %0d out_of_range expected %0d, actual %0d",
                         $time, p.count, p.date.out_of_range, got.out_of_range);
            if (got !== p.date)
                mismatches++;
        endfunction

        function int unsigned pending();
            return expected_dates.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [COUNT_W-1:0] day_count;
    logic               done;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [WDAY_W-1:0]  weekday;
    logic               out_of_range;

    date_scoreboard sb;
    int unsigned    idle_cycles;

    day_count_to_calendar_date_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .day_count    (day_count),
        .done         (done),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .weekday      (weekday),
        .out_of_range (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Check the result first so a start taken on the done cycle queues behind it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_date('{year, month, day_of_month, weekday, out_of_range});
            if (start && !busy)
                sb.note_count(day_count);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((start && !busy) || done))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_count(logic [COUNT_W-1:0] count, int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        day_count <= count;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [COUNT_W-1:0] near_boundary(int unsigned base);
        int signed c;
        c = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (c < 0)
            c = 0;
        if (c > int'(FINAL_DAY) + 2)
            c = int'(FINAL_DAY) + 2;
        return COUNT_W'(c);
    endfunction

    function automatic logic [COUNT_W-1:0] random_count();
        logic [COUNT_W-1:0] c;
        case ($urandom_range(0, 9))
            0: c = COUNT_W'($urandom_range(FINAL_DAY + 1, MAX_COUNT));
            1: c = COUNT_W'($urandom);
            2: c = near_boundary($urandom_range(0, 2000) * DAYS_IN_4Y);
            3: c = near_boundary($urandom_range(0, 80) * DAYS_IN_CENT
                                 + $urandom_range(0, 1));
            4: c = near_boundary($urandom_range(0, 20) * DAYS_IN_400Y);
            default: c = COUNT_W'($urandom_range(0, FINAL_DAY));
        endcase
        return c;
    endfunction

    initial
    begin
        int unsigned        directed [$];
        int unsigned        gap;
        bit                 burst;
        logic [COUNT_W-1:0] c;

        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        day_count = '0;
        directed  = '{0, 1, 6, 7, 58, 59, 60, 365, 366, DAYS_IN_4Y + 59,
                      DAYS_IN_CENT, DAYS_IN_CENT + 1, DAYS_IN_CENT + 59,
                      DAYS_IN_CENT + 60, DAYS_IN_400Y - 1, DAYS_IN_400Y,
                      DAYS_IN_400Y + 59, FINAL_DAY - 1, FINAL_DAY, FINAL_DAY + 1,
                      MAX_COUNT, 2796202, 1398101};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_count(COUNT_W'(directed[i]), $urandom_range(0, MAX_GAP));

        // Hold off until the converter has gone idle
        drain_results();

        burst = 1'b0;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % BURST_LEN == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_results();
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            c = random_count();
            send_count(c, gap);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d day counts, %0d of them past the last date, %0d mismatches",
                 sb.conversions, sb.past_last_date, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
design/dcc_pkg.sv
design/dcc_sub_unit.sv
design/dcc_mod7.sv
design/day_count_to_calendar_date_core.sv
test/testbench.sv
